// File: hw/rtl/bpa_pkg.sv
// bpa_pkg: sizes, codes, sequencer states and buddy pair index helpers
// for the buddy page allocator; depends on nothing
`default_nettype none

package bpa_pkg;

	localparam int NUM_PAGES    = 4096;
	localparam int PAGE_W       = 12;
	localparam int CNT_W        = 13;
	localparam int NUM_CLASSES  = 12;
	localparam int CLS_W        = 4;
	localparam int LINK_W       = PAGE_W + 1;

	// link word: top bit set means no page
	localparam logic [LINK_W-1:0] LINK_NIL = {1'b1, {PAGE_W{1'b0}}};

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_BLOCK = 2'd1,
		STAT_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_REL,
		S_REL_RD,
		S_REL_CHK,
		S_REL_RM,
		S_PUSH1,
		S_PUSH2,
		S_POP,
		S_POP2,
		S_ACLR,
		S_APAIR,
		S_SPLIT,
		S_SPLIT_NEXT,
		S_DONE
	} state_t;

	// start of the pair bit region of a class
	function automatic logic [PAGE_W-1:0] pair_base(input logic [CLS_W-1:0] cls);
		int b;
		b = 0;
		for (int j = 0; j < NUM_CLASSES; j++) begin
			if (j < int'(cls))
				b = b + (NUM_PAGES >> (j + 1));
		end
		return PAGE_W'(b);
	endfunction

	function automatic logic [PAGE_W-1:0] pair_index(input logic [PAGE_W-1:0] pg,
			input logic [CLS_W-1:0] cls);
		logic [PAGE_W-1:0] sh;
		sh = pg >> ({1'b0, cls} + 5'd1);
		return pair_base(cls) + sh;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/buddy_page_allocator.sv
// buddy_page_allocator: buddy allocator over 4096 pages, twelve size classes,
// sequenced over one set of single-port-write memories; depends on bpa_pkg
//
// usage
//   slave channel s_*: one transfer is one command. s_tuser[0] selects
//   allocate (0) or free (1); s_tdata carries the page and the page count.
//   master channel m_*: one transfer per command with the status and the
//   first page of an allocated block (zero otherwise).
// timing
//   a command is taken only while the sequencer is idle; one command at a time.
//   allocate: pop a block from its class list, clear the free map for each
//   page of the count, then split off the unused part one size class at a time.
//   free: check every page for being already free, then per page mark it free,
//   merge it with its free buddy level by level and push the resulting block
//   onto its class list.
//   the rate is set by the single write port of each link/bit memory.
// reset
//   arst_n clears the list heads and the output valid flag, then a clearing
//   pass zeros the pair bits and the free map, one page per cycle;
//   s_tready stays low during that pass. the pool starts empty.
// stalls
//   the result sits in an output register; the next command is taken while
//   it waits. a second result waits in the sequencer until m_tready frees it.
`default_nettype none

module buddy_page_allocator
	import bpa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [31:0] s_tdata,  // page[11:0], count[24:12], zero pad
	input  wire logic [0:0]  s_tuser,  // command[0]
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [15:0] m_tdata   // status[1:0], block_page[13:2], zero pad
);

	state_t state_q, state_nx;

	// control and working registers
	logic [PAGE_W-1:0] clr_q;
	logic              cmd_q;
	logic [PAGE_W-1:0] page_q;
	logic [CNT_W-1:0]  count_q;
	logic [PAGE_W-1:0] k_q;
	logic [CLS_W-1:0]  i_q;
	logic [CLS_W-1:0]  cls_q;
	logic [PAGE_W-1:0] cur_q;
	logic [LINK_W-1:0] hd_q;
	logic [PAGE_W-1:0] begin_q;
	logic [PAGE_W-1:0] pg_q;
	logic [CNT_W-1:0]  rem_q;
	status_t           status_q;
	logic [PAGE_W-1:0] block_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [PAGE_W-1:0] out_block_q;
	logic [LINK_W-1:0] head_q [NUM_CLASSES];

	// memories
	logic [LINK_W-1:0] nxt_mem [NUM_PAGES];
	logic [LINK_W-1:0] prv_mem [NUM_PAGES];
	logic              pair_mem [NUM_PAGES];
	logic              fm_mem [NUM_PAGES];

	logic [LINK_W-1:0] nxt_rd_q, prv_rd_q;
	logic              pair_rd_q, fm_rd_q;

	logic              nxt_we, prv_we, pair_we, fm_we;
	logic [PAGE_W-1:0] nxt_wa, prv_wa, pair_wa, fm_wa;
	logic [LINK_W-1:0] nxt_wd, prv_wd;
	logic              pair_wd, fm_wd;
	logic [PAGE_W-1:0] nxt_ra, prv_ra, pair_ra, fm_ra;

	logic              head_we;
	logic [LINK_W-1:0] head_wd;

	// shared arithmetic
	logic [CLS_W-1:0]  c0;
	logic [CLS_W-1:0]  found;
	logic              found_ok;
	logic              bad_cnt, range_bad, k_last;
	logic [CNT_W-1:0]  size_i;
	logic [PAGE_W-1:0] bit_i, bud, push_pg, scan_pg;
	logic              split_eq, split_low;

	function automatic logic [CLS_W-1:0] ceil_cls(input logic [CNT_W-1:0] n);
		logic [CLS_W-1:0] r;
		r = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if ((CNT_W'(1) << c) >= n)
				r = CLS_W'(c);
		end
		return r;
	endfunction

	assign c0        = ceil_cls(count_q);
	assign bad_cnt   = (count_q == '0) || (count_q > (CNT_W'(1) << (NUM_CLASSES - 1)));
	assign range_bad = ({2'b00, page_q} + {1'b0, count_q}) > 14'(NUM_PAGES);
	assign k_last    = ({1'b0, k_q} + CNT_W'(1)) == count_q;
	assign size_i    = CNT_W'(1) << i_q;
	assign bit_i     = PAGE_W'(1) << i_q;
	assign bud       = cur_q ^ bit_i;
	assign push_pg   = (cmd_q == CMD_FREE) ? cur_q : (pg_q + size_i[PAGE_W-1:0]);
	assign scan_pg   = page_q + k_q;
	assign split_eq  = (size_i << 1) == rem_q;
	assign split_low = rem_q <= size_i;

	// smallest nonempty class at or above c0
	always_comb begin
		found_ok = 1'b0;
		found    = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (!head_q[c][LINK_W-1] && (CLS_W'(c) >= c0)) begin
				found_ok = 1'b1;
				found    = CLS_W'(c);
			end
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == PAGE_W'(NUM_PAGES - 1))
					state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid)
					state_nx = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (cmd_q == CMD_ALLOC) begin
					state_nx = (bad_cnt || !found_ok) ? S_DONE : S_POP;
				end else begin
					state_nx = (range_bad || count_q == '0) ? S_DONE : S_SCAN_RD;
				end
			end
			S_SCAN_RD:  state_nx = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (fm_rd_q)
					state_nx = S_DONE;
				else if (k_last)
					state_nx = S_REL;
				else
					state_nx = S_SCAN_RD;
			end
			S_REL:      state_nx = S_REL_RD;
			S_REL_RD: begin
				state_nx = (i_q == CLS_W'(NUM_CLASSES - 1)) ? S_PUSH1 : S_REL_CHK;
			end
			S_REL_CHK:  state_nx = pair_rd_q ? S_REL_RM : S_PUSH1;
			S_REL_RM:   state_nx = S_REL_RD;
			S_PUSH1:    state_nx = S_PUSH2;
			S_PUSH2: begin
				if (cmd_q == CMD_FREE)
					state_nx = k_last ? S_DONE : S_REL;
				else
					state_nx = S_SPLIT_NEXT;
			end
			S_POP:      state_nx = S_POP2;
			S_POP2:     state_nx = S_ACLR;
			S_ACLR: begin
				if (k_last)
					state_nx = S_APAIR;
			end
			S_APAIR:    state_nx = (cls_q == '0) ? S_DONE : S_SPLIT;
			S_SPLIT: begin
				if (split_eq)
					state_nx = S_DONE;
				else if (split_low)
					state_nx = S_PUSH1;
				else
					state_nx = S_SPLIT_NEXT;
			end
			S_SPLIT_NEXT: state_nx = (i_q == '0) ? S_DONE : S_SPLIT;
			S_DONE: begin
				if (!out_valid_q || m_tready)
					state_nx = S_IDLE;
			end
			default:    state_nx = S_IDLE;
		endcase
	end

	// memory and list head controls
	always_comb begin
		nxt_we  = 1'b0; nxt_wa  = '0; nxt_wd  = LINK_NIL; nxt_ra  = '0;
		prv_we  = 1'b0; prv_wa  = '0; prv_wd  = LINK_NIL; prv_ra  = '0;
		pair_we = 1'b0; pair_wa = '0; pair_wd = 1'b0;     pair_ra = '0;
		fm_we   = 1'b0; fm_wa   = '0; fm_wd   = 1'b0;     fm_ra   = '0;
		head_we = 1'b0; head_wd = LINK_NIL;
		case (state_q)
			S_CLEAR: begin
				pair_we = 1'b1; pair_wa = clr_q; pair_wd = 1'b0;
				fm_we   = 1'b1; fm_wa   = clr_q; fm_wd   = 1'b0;
			end
			S_SCAN_RD: fm_ra = scan_pg;
			S_REL: begin
				fm_we = 1'b1; fm_wa = scan_pg; fm_wd = 1'b1;
			end
			S_REL_RD: pair_ra = pair_index(cur_q, i_q);
			S_REL_CHK: begin
				pair_we = 1'b1;
				pair_wa = pair_index(cur_q, i_q);
				pair_wd = ~pair_rd_q;
				nxt_ra  = bud;
				prv_ra  = bud;
			end
			S_REL_RM: begin
				// unlink the buddy from its class list
				if (!nxt_rd_q[LINK_W-1]) begin
					prv_we = 1'b1; prv_wa = nxt_rd_q[PAGE_W-1:0]; prv_wd = prv_rd_q;
				end
				if (!prv_rd_q[LINK_W-1]) begin
					nxt_we = 1'b1; nxt_wa = prv_rd_q[PAGE_W-1:0]; nxt_wd = nxt_rd_q;
				end else if (head_q[i_q] == {1'b0, bud}) begin
					head_we = 1'b1; head_wd = nxt_rd_q;
				end
			end
			S_PUSH1: begin
				prv_we  = 1'b1; prv_wa = push_pg; prv_wd = LINK_NIL;
				nxt_we  = 1'b1; nxt_wa = push_pg; nxt_wd = head_q[i_q];
				head_we = 1'b1; head_wd = {1'b0, push_pg};
			end
			S_PUSH2: begin
				if (!hd_q[LINK_W-1]) begin
					prv_we = 1'b1; prv_wa = hd_q[PAGE_W-1:0]; prv_wd = {1'b0, push_pg};
				end
				if (cmd_q == CMD_ALLOC) begin
					pair_we = 1'b1; pair_wa = pair_index(pg_q, i_q); pair_wd = 1'b1;
				end
			end
			S_POP: nxt_ra = head_q[i_q][PAGE_W-1:0];
			S_POP2: begin
				head_we = 1'b1; head_wd = nxt_rd_q;
				if (!nxt_rd_q[LINK_W-1]) begin
					prv_we = 1'b1; prv_wa = nxt_rd_q[PAGE_W-1:0]; prv_wd = LINK_NIL;
				end
			end
			S_ACLR: begin
				fm_we = 1'b1; fm_wa = begin_q + k_q; fm_wd = 1'b0;
			end
			S_APAIR: begin
				if (cls_q != CLS_W'(NUM_CLASSES - 1)) begin
					pair_we = 1'b1; pair_wa = pair_index(begin_q, cls_q); pair_wd = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// memories, registered read data
	always_ff @(posedge clk) begin
		if (nxt_we)
			nxt_mem[nxt_wa] <= nxt_wd;
		nxt_rd_q <= nxt_mem[nxt_ra];
	end

	always_ff @(posedge clk) begin
		if (prv_we)
			prv_mem[prv_wa] <= prv_wd;
		prv_rd_q <= prv_mem[prv_ra];
	end

	always_ff @(posedge clk) begin
		if (pair_we)
			pair_mem[pair_wa] <= pair_wd;
		pair_rd_q <= pair_mem[pair_ra];
	end

	always_ff @(posedge clk) begin
		if (fm_we)
			fm_mem[fm_wa] <= fm_wd;
		fm_rd_q <= fm_mem[fm_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < NUM_CLASSES; c++)
				head_q[c] <= LINK_NIL;
		end else begin
			state_q <= state_nx;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + PAGE_W'(1);
			if (head_we)
				head_q[i_q] <= head_wd;
			if (state_q == S_DONE && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q   <= s_tuser[0];
				page_q  <= s_tdata[PAGE_W-1:0];
				count_q <= s_tdata[PAGE_W+CNT_W-1:PAGE_W];
			end
			S_DISPATCH: begin
				k_q     <= '0;
				block_q <= '0;
				i_q     <= found;
				cls_q   <= found;
				if (cmd_q == CMD_ALLOC)
					status_q <= (bad_cnt || !found_ok) ? STAT_NO_BLOCK : STAT_OK;
				else
					status_q <= range_bad ? STAT_BAD_FREE : STAT_OK;
			end
			S_SCAN_CHK: begin
				if (fm_rd_q)
					status_q <= STAT_BAD_FREE;
				k_q <= k_last ? '0 : k_q + PAGE_W'(1);
			end
			S_REL: begin
				cur_q <= scan_pg;
				i_q   <= '0;
			end
			S_REL_RM: begin
				cur_q <= cur_q & ~bit_i;
				i_q   <= i_q + CLS_W'(1);
			end
			S_PUSH1: hd_q <= head_q[i_q];
			S_PUSH2: begin
				if (cmd_q == CMD_FREE)
					k_q <= k_q + PAGE_W'(1);
			end
			S_POP:  begin_q <= head_q[i_q][PAGE_W-1:0];
			S_POP2: k_q <= '0;
			S_ACLR: k_q <= k_q + PAGE_W'(1);
			S_APAIR: begin
				pg_q     <= begin_q;
				rem_q    <= count_q;
				i_q      <= cls_q - CLS_W'(1);
				status_q <= STAT_OK;
				block_q  <= begin_q;
			end
			S_SPLIT: begin
				// keep the lower half for the request, move into the upper half
				if (!split_eq && !split_low) begin
					rem_q <= rem_q - size_i;
					pg_q  <= pg_q + size_i[PAGE_W-1:0];
				end
			end
			S_SPLIT_NEXT: i_q <= i_q - CLS_W'(1);
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_status_q <= status_q;
					out_block_q  <= block_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_block_q, out_status_q};

endmodule

`default_nettype wire
